/* hw/rtl/serial_addressed_rgb_pwm_driver_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef SERIAL_ADDRESSED_RGB_PWM_DRIVER_MACROS_SVH
`define SERIAL_ADDRESSED_RGB_PWM_DRIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/srpd_pkg.sv */
package srpd_pkg;

  localparam int NUM_LEDS_DEFAULT = 4;

  localparam int CNT_W = 9;

  localparam logic [7:0]       FIRST_CODE_RESET   = 8'd101;
  localparam logic [CNT_W-1:0] PWM_PERIOD_RESET   = 9'd300;
  localparam logic [CNT_W-1:0] GREEN_OFFSET_RESET = 9'd100;
  localparam logic [CNT_W-1:0] BLUE_OFFSET_RESET  = 9'd200;

  // Color levels of one LED.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // PWM position and window starts shared by all LEDs.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] green_offset;
    logic [CNT_W-1:0] blue_offset;
  } win_t;

endpackage

/* hw/rtl/serial_addressed_rgb_pwm_driver.sv */
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      func, rx_byte
// out      output     out_valid / out_ready    led1_on, led2_on, led3_on, led4_on
// cfg      input      cfg_we (no wait)         cfg_index, cfg_data
//
// One item per cycle sustained while no tick waits on a stalled output: an item is
// registered on transfer, then takes one byte decode or twelve window compares.
// A tick loads the output register; a byte only updates selection, staging and levels.
// A tick result passes through the input register, then the output register.
// rst is synchronous, active high: registers, levels and counter return to defaults.
// A stalled output holds a waiting tick in the input register and the input behind it;
// bytes keep flowing while only a result waits.

`include "serial_addressed_rgb_pwm_driver_macros.svh"

module serial_addressed_rgb_pwm_driver #(
  parameter int NUM_LEDS = srpd_pkg::NUM_LEDS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] led1_on,
  output logic [2:0] led2_on,
  output logic [2:0] led3_on,
  output logic [2:0] led4_on,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int CNT_W = srpd_pkg::CNT_W;
  localparam int SEL_W = $clog2(NUM_LEDS + 1);
  localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [7:0] NUM_LEDS_B = 8'(NUM_LEDS);
  localparam int NUM_PORTS = 4;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    REG_FIRST_CODE   = 2'd0,
    REG_PWM_PERIOD   = 2'd1,
    REG_GREEN_OFFSET = 2'd2,
    REG_BLUE_OFFSET  = 2'd3
  } cfg_reg_t;

  // Configuration
  logic [7:0]       first_code;
  logic [CNT_W-1:0] pwm_period;
  logic [CNT_W-1:0] green_offset;
  logic [CNT_W-1:0] blue_offset;

  // Input register
  logic       s1_valid;
  logic       s1_func;
  logic [7:0] s1_byte;

  // Protocol and PWM state
  logic [SEL_W-1:0]  sel;
  logic [1:0]        idx;
  logic [7:0]        staging [3];
  srpd_pkg::rgb_t    levels [NUM_LEDS];
  logic [CNT_W-1:0]  tick_count;

  // Output register
  logic [2:0] out_bits [NUM_PORTS];

  logic s1_adv;
  logic tick_fire;
  logic byte_fire;

  // A byte never needs the output; a tick needs room in the output register.
  assign s1_adv    = s1_valid && ((s1_func == FUNC_BYTE) || !out_valid || out_ready);
  assign tick_fire = s1_adv && (s1_func == FUNC_TICK);
  assign byte_fire = s1_adv && (s1_func == FUNC_BYTE);
  assign in_ready  = !s1_valid || s1_adv;

  // ---- Byte decode ----
  logic [SEL_W-1:0] sel_next;
  logic [1:0]       idx_next;
  logic             commit;
  logic [LED_W-1:0] commit_led;
  logic [8:0]       code_diff;
  logic             code_match;

  always_comb begin
    sel_next   = sel;
    idx_next   = idx;
    commit     = 1'b0;
    commit_led = LED_W'(sel - SEL_W'(1));
    code_diff  = {1'b0, s1_byte} - {1'b0, first_code};
    code_match = !code_diff[8] && (code_diff[7:0] < NUM_LEDS_B);
    if (sel != '0) begin
      idx_next = idx + 2'd1;
      // Third data byte: commit the triple and drop the selection.
      if (idx_next == 2'd3) begin
        commit   = 1'b1;
        sel_next = '0;
      end
    end
    // Every byte is also checked as a device code.
    if (code_match) begin
      sel_next = SEL_W'(code_diff[7:0] + 8'd1);
      idx_next = 2'd0;
    end
  end

  // ---- Tick compare ----
  logic [CNT_W-1:0] count_cur;
  srpd_pkg::win_t   win;
  logic [2:0]       led_bits [NUM_LEDS];
  logic [2:0]       show_bits [NUM_PORTS];

  // Clamp an out-of-range counter back to the start of the period.
  assign count_cur = ((tick_count == '0) || (tick_count > pwm_period)) ?
                     CNT_W'(1) : tick_count;

  assign win.count        = count_cur;
  assign win.green_offset = green_offset;
  assign win.blue_offset  = blue_offset;

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    srpd_led_cmp u_cmp (
      .win   (win),
      .level (levels[i]),
      .bits  (led_bits[i])
    );
  end

  // LEDs beyond the configured count stay dark.
  for (genvar k = 0; k < NUM_PORTS; k++) begin : g_port
    if (k < NUM_LEDS) begin : g_used
      assign show_bits[k] = led_bits[k];
    end else begin : g_unused
      assign show_bits[k] = 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code   <= srpd_pkg::FIRST_CODE_RESET;
      pwm_period   <= srpd_pkg::PWM_PERIOD_RESET;
      green_offset <= srpd_pkg::GREEN_OFFSET_RESET;
      blue_offset  <= srpd_pkg::BLUE_OFFSET_RESET;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      sel          <= '0;
      idx          <= 2'd0;
      tick_count   <= CNT_W'(1);
      for (int j = 0; j < 3; j++) begin
        staging[j] <= 8'd0;
      end
      for (int j = 0; j < NUM_LEDS; j++) begin
        levels[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FIRST_CODE:   first_code   <= cfg_data[7:0];
          REG_PWM_PERIOD:   pwm_period   <= cfg_data;
          REG_GREEN_OFFSET: green_offset <= cfg_data;
          REG_BLUE_OFFSET:  blue_offset  <= cfg_data;
        endcase
      end

      // Hold the input register until it advances.
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_func  <= func;
        s1_byte  <= rx_byte;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (byte_fire) begin
        sel <= sel_next;
        idx <= idx_next;
        if ((sel != '0) && (idx != 2'd3)) begin
          staging[idx] <= s1_byte;
        end
        if (commit) begin
          levels[commit_led] <= '{red: staging[0], green: staging[1], blue: s1_byte};
        end
      end

      if (tick_fire) begin
        tick_count <= count_cur + CNT_W'(1);
        out_valid  <= 1'b1;
        for (int k = 0; k < NUM_PORTS; k++) begin
          out_bits[k] <= show_bits[k];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign led1_on = out_bits[0];
  assign led2_on = out_bits[1];
  assign led3_on = out_bits[2];
  assign led4_on = out_bits[3];

  // ---- Assertions ----
  `SRPD_ASSERT_NEXT(a_tick_gives_result, clk, rst, tick_fire, out_valid, "tick lost its result")
  `SRPD_ASSERT_NEXT(a_byte_no_result, clk, rst, byte_fire && (!out_valid || out_ready), !out_valid, "byte made a result")
  `SRPD_ASSERT_IMPL(a_sel_state, clk, rst, sel != '0, (sel <= SEL_W'(NUM_LEDS)) && (idx != 2'd3), "bad selection state")
  `SRPD_ASSERT_IMPL(a_ready_stall, clk, rst, !in_ready, s1_valid && (s1_func == FUNC_TICK) && out_valid && !out_ready, "input stalled without cause")

endmodule

/* hw/rtl/srpd_led_cmp.sv */
module srpd_led_cmp (
  input  srpd_pkg::win_t win,
  input  srpd_pkg::rgb_t level,
  output logic [2:0]     bits
);

  logic [srpd_pkg::CNT_W:0] green_end;
  logic [srpd_pkg::CNT_W:0] blue_end;

  // Window ends are one bit wider so they never wrap.
  assign green_end = {1'b0, win.green_offset} + {2'b00, level.green};
  assign blue_end  = {1'b0, win.blue_offset} + {2'b00, level.blue};

  always_comb begin
    bits[0] = (win.count != '0) && (win.count <= {1'b0, level.red});
    bits[1] = (win.count >= win.green_offset) && ({1'b0, win.count} < green_end);
    bits[2] = (win.count >= win.blue_offset) && ({1'b0, win.count} < blue_end);
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int LEDS        = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  // Item kinds on the func input.
  typedef enum logic {ITEM_BYTE = 1'b0, ITEM_TICK = 1'b1} item_kind_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_FIRST_CODE = 2'd0,
    REG_PERIOD     = 2'd1,
    REG_GREEN_OFS  = 2'd2,
    REG_BLUE_OFS   = 2'd3
  } reg_index_t;

  // One PWM frame: entry i holds the drive bits of LED i+1 (bit0 red, bit1 green, bit2 blue).
  typedef logic [LEDS-1:0][2:0] led_frame_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       func;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] led1_on;
  logic [2:0] led2_on;
  logic [2:0] led3_on;
  logic [2:0] led4_on;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  // Run control: calm turns off all idling on both sides for the last part of the run.
  logic calm;
  int   sink_hold;
  int   cycle_count;
  int   fail_count;
  int   frames_checked;
  int   ticks_sent;
  int   bytes_sent;
  int   commits_seen;
  int   settings_used;

  // Mirror of the block: register file, serial capture state, level table, PWM counter.
  logic [7:0]                 code_base;
  logic [srpd_pkg::CNT_W-1:0] period_reg;
  logic [srpd_pkg::CNT_W-1:0] green_ofs;
  logic [srpd_pkg::CNT_W-1:0] blue_ofs;
  int                         sel_led;
  logic [1:0]                 byte_idx;
  logic [7:0]                 staged [3];
  srpd_pkg::rgb_t             levels [LEDS];
  logic [srpd_pkg::CNT_W-1:0] pwm_pos;

  // Frames still owed by the block, oldest first.
  led_frame_t pending_frames[$];

  serial_addressed_rgb_pwm_driver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led1_on   (led1_on),
    .led2_on   (led2_on),
    .led3_on   (led3_on),
    .led4_on   (led4_on),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Abort a hung run: no legal run gets anywhere near this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d frames outstanding",
               cycle_count, pending_frames.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts, none while calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      sink_hold <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void note_failure(input string msg);
    if (fail_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
    fail_count++;
  endfunction

  function automatic void reset_model();
    code_base  = srpd_pkg::FIRST_CODE_RESET;
    period_reg = srpd_pkg::PWM_PERIOD_RESET;
    green_ofs  = srpd_pkg::GREEN_OFFSET_RESET;
    blue_ofs   = srpd_pkg::BLUE_OFFSET_RESET;
    sel_led    = 0;
    byte_idx   = 2'd0;
    pwm_pos    = 9'd1;
    for (int i = 0; i < 3; i++) staged[i] = 8'd0;
    for (int i = 0; i < LEDS; i++) levels[i] = '0;
  endfunction

  // Serial byte: store into the capture of the selected LED, commit on the third byte,
  // then check the same byte as a device code (it may reselect).
  function automatic void predict_byte(input logic [7:0] b);
    if (sel_led > 0 && sel_led <= LEDS) begin
      if (byte_idx < 2'd3) staged[byte_idx] = b;
      byte_idx = byte_idx + 2'd1;
      if (byte_idx == 2'd3) begin
        levels[sel_led - 1] = '{red: staged[0], green: staged[1], blue: staged[2]};
        sel_led = 0;
        commits_seen++;
      end
    end
    if (b >= code_base && (int'(b) - int'(code_base)) < LEDS) begin
      sel_led  = int'(b) - int'(code_base) + 1;
      byte_idx = 2'd0;
    end
  endfunction

  // PWM tick: pull an out-of-range count back to 1, compare all windows, advance.
  function automatic led_frame_t predict_tick();
    led_frame_t frame;
    int         pos;
    pos = int'(pwm_pos);
    if (pos == 0 || pos > int'(period_reg)) pos = 1;
    for (int i = 0; i < LEDS; i++) begin
      frame[i][0] = (pos >= 1 && pos <= int'(levels[i].red));
      frame[i][1] = (pos >= int'(green_ofs) && pos < int'(green_ofs) + int'(levels[i].green));
      frame[i][2] = (pos >= int'(blue_ofs) && pos < int'(blue_ofs) + int'(levels[i].blue));
    end
    pwm_pos = srpd_pkg::CNT_W'((pos + 1) & 511);
    return frame;
  endfunction

  // Present one item, hold it until the transfer, then update the mirror.
  task automatic send_item(input item_kind_t kind, input logic [7:0] value);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= kind;
    rx_byte  <= value;
    do @(posedge clk); while (!in_ready);
    if (kind == ITEM_TICK) begin
      pending_frames.push_back(predict_tick());
      ticks_sent++;
    end else begin
      predict_byte(value);
      bytes_sent++;
    end
  endtask

  // The byte lane carries junk on ticks; the block has to ignore it.
  task automatic send_tick();
    send_item(ITEM_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] code_for(input int led);
    return 8'(int'(code_base) + led);
  endfunction

  // Drop valid, let every owed frame drain, then give the pipeline time to go quiet.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back while the block is idle.
  task automatic write_config(input logic [7:0] first, input logic [8:0] period,
                              input logic [8:0] goff, input logic [8:0] boff);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIRST_CODE;
    cfg_data  <= {1'b0, first};
    @(posedge clk);
    cfg_index <= REG_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_index <= REG_GREEN_OFS;
    cfg_data  <= goff;
    @(posedge clk);
    cfg_index <= REG_BLUE_OFS;
    cfg_data  <= boff;
    @(posedge clk);
    cfg_we     <= 1'b0;
    code_base  = first;
    period_reg = period;
    green_ofs  = goff;
    blue_ofs   = boff;
    settings_used++;
  endtask

  // Level bytes: small values make windows visible, some land on device codes.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 15));
      1:       return code_for($urandom_range(0, LEDS - 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Compare each frame against the oldest prediction, field by field.
  always @(posedge clk) begin : frame_check
    led_frame_t seen;
    led_frame_t want;
    if (!rst && out_valid && out_ready) begin
      seen = {led4_on, led3_on, led2_on, led1_on};
      if (pending_frames.size() == 0) begin
        note_failure($sformatf("frame with nothing expected: %b %b %b %b",
                               led1_on, led2_on, led3_on, led4_on));
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        for (int i = 0; i < LEDS; i++) begin
          if (seen[i] !== want[i])
            note_failure($sformatf("frame %0d led%0d_on: expected %b, got %b",
                                   frames_checked, i + 1, want[i], seen[i]));
        end
      end
    end
  end

  // Reset defaults: dark table, then program LED four with the default code base.
  task automatic test_reset_state();
    send_tick();
    send_item(ITEM_BYTE, code_for(3));
    send_item(ITEM_BYTE, 8'd20);
    send_item(ITEM_BYTE, 8'd30);
    send_item(ITEM_BYTE, 8'd40);
    send_tick();
  endtask

  // Short period so one sweep crosses every window edge and wraps the counter.
  task automatic test_windows();
    write_config(8'd10, 9'd6, 9'd2, 9'd4);
    send_item(ITEM_BYTE, code_for(0));
    send_item(ITEM_BYTE, 8'd255);
    send_item(ITEM_BYTE, 8'd0);
    send_item(ITEM_BYTE, 8'd3);
    repeat (7) send_tick();
  endtask

  // Highest code base: code 255 is LED four, and a code arriving as data is both
  // stored and taken as a new selection. The period drops below the running count.
  task automatic test_code_edges();
    write_config(8'd252, 9'd3, 9'd1, 9'd2);
    send_item(ITEM_BYTE, 8'd255);
    send_item(ITEM_BYTE, 8'd255);
    send_item(ITEM_BYTE, 8'd7);
    send_item(ITEM_BYTE, 8'd9);
    send_item(ITEM_BYTE, 8'd11);
    send_tick();
    send_tick();
  endtask

  // Period zero acts as one; code base zero.
  task automatic test_zero_period();
    write_config(8'd0, 9'd0, 9'd0, 9'd1);
    send_item(ITEM_BYTE, code_for(0));
    send_item(ITEM_BYTE, 8'd5);
    send_item(ITEM_BYTE, 8'd1);
    send_item(ITEM_BYTE, 8'd1);
    send_tick();
    send_tick();
  endtask

  // Full 511 period with a zero blue offset: wide windows stay lit from the first count.
  task automatic test_long_period();
    write_config(srpd_pkg::FIRST_CODE_RESET, 9'd511, 9'd20, 9'd0);
    send_item(ITEM_BYTE, code_for(1));
    send_item(ITEM_BYTE, 8'd255);
    send_item(ITEM_BYTE, 8'd20);
    send_item(ITEM_BYTE, 8'd255);
    repeat (45) send_tick();
  endtask

  // Mostly complete LED writes with ticks mixed in, plus broken writes and noise.
  task automatic random_traffic(input int n);
    int done;
    int k;
    done = 0;
    while (done < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_item(ITEM_BYTE, code_for($urandom_range(0, LEDS - 1)));
          for (int j = 0; j < 3; j++) begin
            if ($urandom_range(0, 3) == 0) send_tick();
            send_item(ITEM_BYTE, rand_level());
          end
          done += 4;
        end
        4, 5, 6: begin
          k = $urandom_range(1, 8);
          repeat (k) send_tick();
          done += k;
        end
        7, 8: begin
          // Cut a write short; whatever follows lands in the stale capture.
          k = $urandom_range(1, 2);
          send_item(ITEM_BYTE, code_for($urandom_range(0, LEDS - 1)));
          repeat (k) send_item(ITEM_BYTE, rand_level());
          done += k + 1;
        end
        default: begin
          send_item(ITEM_BYTE, 8'($urandom_range(0, 255)));
          done++;
        end
      endcase
    end
  endtask

  // Several random register settings, extremes weighted in; the last phase runs calm.
  task automatic test_random();
    logic [7:0] first;
    logic [8:0] period;
    logic [8:0] goff;
    logic [8:0] boff;
    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 3))
        0:       first = 8'd0;
        1:       first = 8'd252;
        default: first = 8'($urandom_range(0, 252));
      endcase
      case ($urandom_range(0, 4))
        0:       period = 9'd1;
        1:       period = 9'd511;
        2, 3:    period = 9'($urandom_range(2, 40));
        default: period = 9'($urandom_range(1, 511));
      endcase
      goff = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, period));
      boff = ($urandom_range(0, 3) == 0) ? 9'd511 : 9'($urandom_range(0, period));
      write_config(first, period, goff, boff);
      if (phase == 6) calm <= 1'b1;
      random_traffic(45);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= ITEM_BYTE;
    rx_byte     <= 8'd0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_FIRST_CODE;
    cfg_data    <= 9'd0;
    out_ready   <= 1'b0;
    calm        <= 1'b0;
    sink_hold   = 0;
    cycle_count = 0;
    fail_count  = 0;
    frames_checked = 0;
    ticks_sent  = 0;
    bytes_sent  = 0;
    commits_seen  = 0;
    settings_used = 0;
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_windows();
    test_code_edges();
    test_zero_period();
    test_long_period();
    test_random();
    quiesce();

    $display("Run covered %0d ticks and %0d serial bytes (%0d color commits) under %0d settings",
             ticks_sent, bytes_sent, commits_seen, settings_used);
    $display("%0d frames compared, %0d mismatches", frames_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
